// ===== rtl/core/int_to_decimal_ascii_unit_macros.svh =====
// Assertion macros shared by the checker of the decimal text converter.
// No dependencies; the user provides clk and rst in scope.
`ifndef INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ITOA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define ITOA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/itoa_pkg.sv =====
// Constants and helper functions for the integer to decimal text converter.
// No dependencies.
package itoa_pkg;

  localparam int BIN_W      = 32;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int WORK_W     = BCD_W + BIN_W;
  localparam int DD_STEPS   = 8;
  localparam int DD_STAGES  = BIN_W / DD_STEPS;
  localparam int IDX_W      = 4;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;
  localparam logic [3:0] DIGIT_FIVE  = 4'd5;
  localparam logic [3:0] DIGIT_ADJ   = 4'd3;

  // Eight shift-and-add-3 steps of the binary to BCD conversion.
  // The BCD digits sit above the binary bits still to be shifted in.
  function automatic logic [WORK_W-1:0] dabble_steps(input logic [WORK_W-1:0] w_in);
    logic [WORK_W-1:0] w;
    w = w_in;
    for (int s = 0; s < DD_STEPS; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (w[BIN_W + 4*d +: 4] >= DIGIT_FIVE) begin
          w[BIN_W + 4*d +: 4] = w[BIN_W + 4*d +: 4] + DIGIT_ADJ;
        end
      end
      w = {w[WORK_W-2:0], 1'b0};
    end
    return w;
  endfunction

  // Number of significant digits, at least one so that zero prints as '0'.
  function automatic logic [IDX_W-1:0] digit_count(input logic [BCD_W-1:0] bcd);
    logic [IDX_W-1:0] n;
    n = IDX_W'(1);
    for (int d = 1; d < NUM_DIGITS; d++) begin
      if (bcd[4*d +: 4] != 4'd0) begin
        n = IDX_W'(d + 1);
      end
    end
    return n;
  endfunction

endpackage

// ===== rtl/core/int_to_decimal_ascii_unit.sv =====
// Top level of the signed 32-bit integer to decimal ASCII converter.
// Depends on itoa_pkg.
//
// A request is taken when start is high and busy is low. The value runs through
// an input stage, a negate stage, four binary-to-BCD stages of eight steps each
// and a digit-count stage into the serializer, whose characters are registered
// onto strobe. The characters then leave one per cycle with no gaps, most
// significant first, '-' ahead of a negative value, last high on the final one.
// The character serializer sets the rate: a value occupies it until all of its
// characters (1 to 11) have left, and a next text waiting in the digit-count
// stage follows with no gap. Up to seven further requests may be held in the
// pipeline; busy rises when the input stage holds a request that cannot move on.
// Results cannot be held off by the receiver.
module int_to_decimal_ascii_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] value,
  output logic        busy,
  output logic        strobe,
  output logic [7:0]  char_code,
  output logic        last
);

  // Input stage.
  logic                          p0_valid;
  logic [itoa_pkg::BIN_W-1:0]    p0_raw;

  // Conversion stages: index 0 holds the magnitude, index k the word after 8k steps.
  logic [itoa_pkg::DD_STAGES:0]  dd_valid;
  logic [itoa_pkg::DD_STAGES:0]  dd_neg;
  logic [itoa_pkg::WORK_W-1:0]   dd_work [itoa_pkg::DD_STAGES+1];

  // Digit-count stage.
  logic                          s_valid;
  logic                          s_neg;
  logic [itoa_pkg::BCD_W-1:0]    s_bcd;
  logic [itoa_pkg::IDX_W-1:0]    s_nd;

  // Serializer.
  logic                          ser_active;
  logic                          ser_sign;
  logic [itoa_pkg::BCD_W-1:0]    ser_bcd;
  logic [itoa_pkg::IDX_W-1:0]    ser_idx;

  logic                          accept;
  logic                          adv;
  logic                          ser_done;
  logic                          ser_load;
  logic [3:0]                    cur_digit;
  logic [itoa_pkg::BIN_W-1:0]    mag;

  assign cur_digit = ser_bcd[{ser_idx, 2'b00} +: 4];
  assign ser_done  = ser_active && !ser_sign && (ser_idx == '0);
  assign ser_load  = s_valid && (!ser_active || ser_done);
  // The whole pipeline moves together unless its output stage waits on the serializer.
  assign adv       = !s_valid || ser_load;
  assign busy      = p0_valid && !adv;
  assign accept    = start && !busy;
  assign mag       = p0_raw[itoa_pkg::BIN_W-1] ? (~p0_raw + itoa_pkg::BIN_W'(1)) : p0_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
    end else if (adv || !p0_valid) begin
      p0_valid <= accept;
    end
    if (accept) begin
      p0_raw <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dd_valid <= '0;
      s_valid  <= 1'b0;
    end else if (adv) begin
      dd_valid <= {dd_valid[itoa_pkg::DD_STAGES-1:0], p0_valid};
      s_valid  <= dd_valid[itoa_pkg::DD_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dd_neg     <= {dd_neg[itoa_pkg::DD_STAGES-1:0], p0_raw[itoa_pkg::BIN_W-1]};
      dd_work[0] <= {{itoa_pkg::BCD_W{1'b0}}, mag};
      for (int k = 1; k <= itoa_pkg::DD_STAGES; k++) begin
        dd_work[k] <= itoa_pkg::dabble_steps(dd_work[k-1]);
      end
      s_neg <= dd_neg[itoa_pkg::DD_STAGES];
      s_bcd <= dd_work[itoa_pkg::DD_STAGES][itoa_pkg::WORK_W-1:itoa_pkg::BIN_W];
      s_nd  <= itoa_pkg::digit_count(
                 dd_work[itoa_pkg::DD_STAGES][itoa_pkg::WORK_W-1:itoa_pkg::BIN_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_active <= 1'b0;
      ser_sign   <= 1'b0;
    end else if (ser_load) begin
      ser_active <= 1'b1;
      ser_sign   <= s_neg;
    end else if (ser_done) begin
      ser_active <= 1'b0;
    end else if (ser_active && ser_sign) begin
      ser_sign <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      ser_bcd <= s_bcd;
      ser_idx <= s_nd - itoa_pkg::IDX_W'(1);
    end else if (ser_active && !ser_sign && (ser_idx != '0)) begin
      ser_idx <= ser_idx - itoa_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ser_active;
    end
    if (ser_sign) begin
      char_code <= itoa_pkg::ASCII_MINUS;
      last      <= 1'b0;
    end else begin
      char_code <= itoa_pkg::ASCII_ZERO + {4'd0, cur_digit};
      last      <= (ser_idx == '0);
    end
  end

endmodule

// ===== rtl/core/itoa_checker.sv =====
// Port-level checker for the decimal text converter, bound to its top level.
// Depends on int_to_decimal_ascii_unit_macros.svh.
`include "int_to_decimal_ascii_unit_macros.svh"

module itoa_checker (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        strobe,
  input logic [7:0]  char_code,
  input logic        last
);

  `ITOA_ASSERT_ALWAYS(a_reset_quiet, rst |=> !strobe && !busy, "output or busy active after reset")
  `ITOA_ASSERT(a_char_range, strobe |-> (char_code == 8'd45) || (char_code >= 8'd48 && char_code <= 8'd57), "character is neither a digit nor a minus sign")
  `ITOA_ASSERT(a_minus_then_digit, strobe && char_code == 8'd45 |-> !last ##1 (strobe && char_code != 8'd45), "minus sign not followed by a digit")
  `ITOA_ASSERT(a_no_gap, strobe && !last |=> strobe, "gap inside the text of one request")
  `ITOA_ASSERT(a_no_leading_zero, strobe && char_code == 8'd48 && !last |-> $past(strobe) && !$past(last) && $past(char_code) != 8'd45, "leading zero in the text")

endmodule

bind int_to_decimal_ascii_unit itoa_checker u_itoa_checker (.*);
